[sv/assert_macros.svh]
// assertion macros used by the queue rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SIMP3_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("simplex noise assertion failed");
// next-cycle implication
`define SIMP3_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("simplex noise assertion failed");
`else
`define SIMP3_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SIMP3_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

[sv/simp3_pkg.sv]
// types, constants and the corner hash of the simplex noise block
`timescale 1ns / 1ps
`default_nettype none

package simp3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int OUT_W     = 18;
    localparam int SUM3_W    = COORD_W + 3;
    localparam int SKEW_W    = SUM3_W - FRAC_BITS;
    localparam int DIVA_W    = SKEW_W + 1;
    localparam int CELL_W    = SKEW_W;
    localparam int CELL_LO_W = 8;
    localparam int OFF_W     = 24;
    localparam int DOFF_W    = OFF_W - FRAC_BITS;
    localparam int SQ_W      = 2 * OFF_W - 1;
    localparam int SSQ_W     = SQ_W + 3;
    localparam int T5_W      = 54;
    localparam int T5S_W     = 23;
    localparam int TQ_W      = 16;
    localparam int GA_W      = OFF_W + 1;
    localparam int G_W       = 22;
    localparam int SUM_W     = 24;
    localparam int FP_W      = TQ_W + 1 + SUM_W;
    localparam int CONTRIB_W = FP_W - (FRAC_BITS - 3);
    localparam int TOTAL_W   = CONTRIB_W + 2;
    localparam int NCORNER   = 4;
    localparam int NSTAGE    = 7;

    // floor divide by three: bias, reciprocal, shift
    localparam int                DIV3_SH   = DIVA_W + 2;
    localparam logic [DIVA_W-1:0] DIV3_BIAS = DIVA_W'(3 * (1 << (SKEW_W - 1)));
    localparam logic [CELL_W-1:0] CELL_BIAS = CELL_W'(1 << (SKEW_W - 1));
    localparam int                RECIP3_W  = 21;
    localparam logic [RECIP3_W-1:0] RECIP3  = 21'd1398102;
    localparam int                PROD3_W   = DIVA_W + RECIP3_W;

    // floor divide by six of a corner offset
    localparam int              DIV6_SH   = 28;
    localparam logic [GA_W-1:0] DIV6_BIAS = GA_W'(6 * (1 << (G_W - 1)));
    localparam logic [G_W-1:0]  G_BIAS    = G_W'(1 << (G_W - 1));
    localparam int              RECIP6_W  = 26;
    localparam logic [RECIP6_W-1:0] RECIP6 = 26'd44739243;
    localparam int              PROD6_W   = GA_W + RECIP6_W;

    // weight: 108 * one^2 - 5 * dist^2, then divide by 180 * one
    localparam logic [T5_W-1:0] T5_BASE   = 54'd463856467968;
    localparam int              DIV180_SH = 31;
    localparam int              RECIP180_W = 24;
    localparam logic [RECIP180_W-1:0] RECIP180 = 24'd11930465;
    localparam int              PROD180_W = T5S_W + RECIP180_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic signed [TOTAL_W-1:0] OUT_MAX = TOTAL_W'(131071);
    localparam logic signed [TOTAL_W-1:0] OUT_MIN = -TOTAL_W'(131072);

    localparam logic [5:0] BIT_TAB [8] = '{6'h15, 6'h38, 6'h32, 6'h2c,
                                           6'h0d, 6'h13, 6'h07, 6'h2a};

    typedef struct packed {
        logic [2:0][CELL_LO_W-1:0] cell_lo;
        logic [2:0][OFF_W-1:0]     off;
        logic [2:0]                m1;
        logic [2:0]                m2;
    } simp3_job_t;

    typedef struct packed {
        logic       valid;
        simp3_job_t job;
    } simp3_slot_t;

    function automatic logic [1:0] next3(input logic [1:0] r);
        return (r == 2'd2) ? 2'd0 : r + 2'd1;
    endfunction

    function automatic logic [5:0] corner_hash(input logic [CELL_LO_W-1:0] a,
                                               input logic [CELL_LO_W-1:0] b,
                                               input logic [CELL_LO_W-1:0] c);
        logic [2:0][CELL_LO_W-1:0] co;
        logic [8:0] h;
        logic [2:0] idx;
        logic [1:0] r0;
        logic [1:0] r1;
        logic [1:0] r2;
        co = {c, b, a};
        h  = '0;
        r0 = 2'd0;
        for (int n = 0; n < CELL_LO_W; n++) begin
            r1  = next3(r0);
            r2  = next3(r1);
            idx = {co[r0][n], co[r1][n], co[r2][n]};
            h   = h + 9'(BIT_TAB[idx]);
            r0  = r1;
        end
        return h[5:0];
    endfunction

endpackage

`default_nettype wire

[sv/simp3_point_if.sv]
// point channel of the simplex noise block
`timescale 1ns / 1ps
`default_nettype none

interface simp3_point_if import simp3_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;

    modport source (output valid, output px, output py, output pz, input ready);
    modport sink   (input valid, input px, input py, input pz, output ready);
endinterface

`default_nettype wire

[sv/simp3_noise_if.sv]
// noise result channel of the simplex noise block
`timescale 1ns / 1ps
`default_nettype none

interface simp3_noise_if import simp3_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

`default_nettype wire

[sv/simp3_front.sv]
// front: skew, cell floor, unskewed offsets and corner ordering
`timescale 1ns / 1ps
`default_nettype none

module simp3_front import simp3_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    simp3_point_if.sink             point,
    input  wire logic [QCNT_W-1:0]  level,
    output simp3_slot_t             push
);

    logic signed [COORD_W-1:0] coord [3];
    logic signed [SUM3_W-1:0]  sall;
    logic                      v1_reg;
    logic                      v1_next;
    logic [PROD3_W-1:0]        prod_reg [3];
    logic [PROD3_W-1:0]        prod_next [3];
    logic [OFF_W-1:0]          xl_reg [3];
    logic [CELL_LO_W-1:0]      cell8 [3];
    logic [CELL_LO_W-1:0]      cs8;
    logic [2:0][OFF_W-1:0]     off;
    logic [1:0]                hi;
    logic [1:0]                lo;
    logic [1:0]                mid;
    logic [2:0]                m1;

    assign coord[0] = point.px;
    assign coord[1] = point.py;
    assign coord[2] = point.pz;
    assign sall = SUM3_W'(coord[0]) + SUM3_W'(coord[1]) + SUM3_W'(coord[2]);

    // credit: never more items in flight than the queue can hold
    assign point.ready = (level + QCNT_W'(v1_reg)) < QCNT_W'(QDEPTH);
    assign v1_next = point.valid && point.ready;

    for (genvar m = 0; m < 3; m++) begin : g_axis
        logic signed [SUM3_W-1:0] own;
        logic signed [SUM3_W-1:0] s;
        logic [DIVA_W-1:0]        a;
        logic [CELL_W-1:0]        q;
        logic [CELL_W-1:0]        cell_val;

        assign own = SUM3_W'(coord[m]);
        assign s   = sall + (own <<< 1) + own;
        assign a   = DIVA_W'($signed(s[SUM3_W-1:FRAC_BITS])) + DIV3_BIAS;
        assign prod_next[m] = PROD3_W'(a) * PROD3_W'(RECIP3);

        assign q        = prod_reg[m][DIV3_SH +: CELL_W];
        assign cell_val = q - CELL_BIAS;
        assign cell8[m] = cell_val[CELL_LO_W-1:0];
    end

    assign cs8 = cell8[0] + cell8[1] + cell8[2];

    always_comb
    begin
        for (int m = 0; m < 3; m++) begin
            off[m] = OFF_W'(xl_reg[m] * OFF_W'(6))
                   + {DOFF_W'(cs8 - CELL_LO_W'(cell8[m] * CELL_LO_W'(6))),
                      {FRAC_BITS{1'b0}}};
        end
    end

    always_comb
    begin
        if ($signed(off[0]) >= $signed(off[2]))
            hi = ($signed(off[0]) >= $signed(off[1])) ? 2'd0 : 2'd1;
        else
            hi = ($signed(off[1]) >= $signed(off[2])) ? 2'd1 : 2'd2;
        if ($signed(off[0]) < $signed(off[2]))
            lo = ($signed(off[0]) < $signed(off[1])) ? 2'd0 : 2'd1;
        else
            lo = ($signed(off[1]) < $signed(off[2])) ? 2'd1 : 2'd2;
        mid = 2'd3 - hi - lo;
        m1  = 3'b001 << hi;
    end

    assign push.valid       = v1_reg;
    assign push.job.cell_lo = {cell8[2], cell8[1], cell8[0]};
    assign push.job.off     = off;
    assign push.job.m1      = m1;
    assign push.job.m2      = m1 | (3'b001 << mid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int m = 0; m < 3; m++) begin
            prod_reg[m] <= prod_next[m];
            xl_reg[m]   <= coord[m][OFF_W-1:0];
        end
    end

endmodule

`default_nettype wire

[sv/simp3_queue.sv]
// short queue between front and back
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module simp3_queue import simp3_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire simp3_slot_t        push,
    input  wire logic               pop,
    output simp3_slot_t             head,
    output logic [QCNT_W-1:0]       level
);

    simp3_job_t         mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign head.valid = (count_reg != '0);
    assign head.job   = mem[rd_ptr_reg];
    assign level      = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push.valid && pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_ptr_reg] <= push.job;
    end

    `SIMP3_ASSERT_IMP(a_no_overflow, clk, rst_n, push.valid, count_reg != QCNT_W'(QDEPTH))
    `SIMP3_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, count_reg != '0)
    `SIMP3_ASSERT_NXT(a_count_hold, clk, rst_n, !push.valid && !pop, count_reg == $past(count_reg))

endmodule

`default_nettype wire

[sv/simp3_back.sv]
// back: four corner lanes, weights, gradients and saturated sum
`timescale 1ns / 1ps
`default_nettype none

module simp3_back import simp3_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire simp3_slot_t head,
    output logic             pop,
    simp3_noise_if.source    result
);

    logic                         en;
    logic [NSTAGE-1:0]            vld_reg;
    logic                         out_valid_reg;
    logic signed [OUT_W-1:0]      noise_reg;
    logic signed [OUT_W-1:0]      noise_next;
    logic signed [CONTRIB_W-1:0]  contrib [NCORNER];
    logic signed [TOTAL_W-1:0]    total;

    assign en  = !out_valid_reg || result.ready;
    assign pop = en && head.valid;

    for (genvar k = 0; k < NCORNER; k++) begin : g_lane
        logic [2:0]                cm;
        logic signed [OFF_W-1:0]   c_reg [3];
        logic [5:0]                h0_reg;
        logic [SQ_W-1:0]           sq_reg [3];
        logic [PROD6_W-1:0]        gp_reg [3];
        logic [5:0]                h1_reg;
        logic [SSQ_W-1:0]          ssq;
        logic [T5_W-1:0]           t5;
        logic [T5S_W-1:0]          t5s_reg;
        logic                      pos2_reg;
        logic signed [G_W-1:0]     g_reg [3];
        logic [5:0]                h2_reg;
        logic [PROD180_W-1:0]      tqp_reg;
        logic signed [SUM_W-1:0]   sum3_reg;
        logic                      pos3_reg;
        logic signed [G_W-1:0]     p;
        logic signed [G_W-1:0]     q;
        logic signed [G_W-1:0]     r;
        logic signed [SUM_W-1:0]   gsum;
        logic [TQ_W-1:0]           tq;
        logic [2*TQ_W-1:0]         t2p_reg;
        logic signed [SUM_W-1:0]   sum4_reg;
        logic                      pos4_reg;
        logic [2*TQ_W-1:0]         t4p_reg;
        logic signed [SUM_W-1:0]   sum5_reg;
        logic                      pos5_reg;
        logic signed [FP_W-1:0]    fp_reg;
        logic                      pos6_reg;

        assign cm = (k == 0) ? 3'b000 :
                    (k == 1) ? head.job.m1 :
                    (k == 2) ? head.job.m2 : 3'b111;

        assign ssq = SSQ_W'(sq_reg[0]) + SSQ_W'(sq_reg[1]) + SSQ_W'(sq_reg[2]);
        assign t5  = T5_BASE - ((T5_W'(ssq) << 2) + T5_W'(ssq));

        // gradient selection and signs from the hash
        always_comb
        begin
            case (h2_reg[1:0])
                2'd1:
                begin
                    p = g_reg[0];
                    q = g_reg[1];
                    r = g_reg[2];
                end
                2'd2:
                begin
                    p = g_reg[1];
                    q = g_reg[2];
                    r = g_reg[0];
                end
                default:
                begin
                    p = g_reg[2];
                    q = g_reg[0];
                    r = g_reg[1];
                end
            endcase
            if (h2_reg[5] == h2_reg[3])
                p = -p;
            if (h2_reg[5] == h2_reg[4])
                q = -q;
            if (h2_reg[5] != (h2_reg[4] ^ h2_reg[3]))
                r = -r;
            if (h2_reg[1:0] == 2'd0)
                gsum = SUM_W'(p) + SUM_W'(q) + SUM_W'(r);
            else if (!h2_reg[2])
                gsum = SUM_W'(p) + SUM_W'(q);
            else
                gsum = SUM_W'(p) + SUM_W'(r);
        end

        assign tq = tqp_reg[DIV180_SH +: TQ_W];
        assign contrib[k] = pos6_reg ? fp_reg[FP_W-1:FRAC_BITS-3] : '0;

        always_ff @(posedge clk)
        begin
            if (en) begin
                for (int m = 0; m < 3; m++) begin
                    c_reg[m] <= $signed(head.job.off[m]
                              + {DOFF_W'(k) - (cm[m] ? DOFF_W'(6) : DOFF_W'(0)),
                                 {FRAC_BITS{1'b0}}});
                    sq_reg[m] <= SQ_W'(c_reg[m] * c_reg[m]);
                    gp_reg[m] <= PROD6_W'(GA_W'(GA_W'(c_reg[m]) + DIV6_BIAS))
                               * PROD6_W'(RECIP6);
                    g_reg[m]  <= gp_reg[m][DIV6_SH +: G_W] - G_BIAS;
                end
                h0_reg <= corner_hash(head.job.cell_lo[0] + CELL_LO_W'(cm[0]),
                                      head.job.cell_lo[1] + CELL_LO_W'(cm[1]),
                                      head.job.cell_lo[2] + CELL_LO_W'(cm[2]));
                h1_reg   <= h0_reg;
                h2_reg   <= h1_reg;
                t5s_reg  <= t5[FRAC_BITS +: T5S_W];
                pos2_reg <= !t5[T5_W-1] && (t5 != '0);
                tqp_reg  <= PROD180_W'(t5s_reg) * PROD180_W'(RECIP180);
                sum3_reg <= gsum;
                pos3_reg <= pos2_reg;
                t2p_reg  <= tq * tq;
                sum4_reg <= sum3_reg;
                pos4_reg <= pos3_reg;
                t4p_reg  <= t2p_reg[TQ_W +: TQ_W] * t2p_reg[TQ_W +: TQ_W];
                sum5_reg <= sum4_reg;
                pos5_reg <= pos4_reg;
                fp_reg   <= $signed({1'b0, t4p_reg[TQ_W +: TQ_W]}) * sum5_reg;
                pos6_reg <= pos5_reg;
            end
        end
    end

    assign total = TOTAL_W'(contrib[0]) + TOTAL_W'(contrib[1])
                 + TOTAL_W'(contrib[2]) + TOTAL_W'(contrib[3]);

    always_comb
    begin
        if (total > OUT_MAX)
            noise_next = OUT_MAX[OUT_W-1:0];
        else if (total < OUT_MIN)
            noise_next = OUT_MIN[OUT_W-1:0];
        else
            noise_next = total[OUT_W-1:0];
    end

    assign result.valid       = out_valid_reg;
    assign result.noise_value = noise_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[NSTAGE-2:0], pop};
            out_valid_reg <= vld_reg[NSTAGE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            noise_reg <= noise_next;
    end

endmodule

`default_nettype wire

[sv/simplex_noise_3d.sv]
// top level of the 3d simplex noise block
// point channel: one item carries px, py, pz, signed q15.16
// result channel: one item carries noise_value, signed q1.16, saturated
// both channels use valid/ready; an item moves when both are high
// every point gives exactly one result, in order
// throughput: one point per cycle while the receiver holds ready high, set by the pipelined back end
// the front computes cell and corner order in one register stage
// a 4-entry queue sits between front and back
// the back runs four corner lanes in parallel through 7 stages
// plus an output register
// when the receiver stalls, the back holds, the queue fills, and then
// the point channel drops ready
// reset empties the queue and clears all valid flags; no other state
`timescale 1ns / 1ps
`default_nettype none

module simplex_noise_3d import simp3_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    simp3_point_if.sink   point,
    simp3_noise_if.source result
);

    simp3_slot_t        push;
    simp3_slot_t        head;
    logic               pop;
    logic [QCNT_W-1:0]  level;

    simp3_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .point (point),
        .level (level),
        .push  (push)
    );

    simp3_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .level (level)
    );

    simp3_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire

[verif/tb_simplex_noise_3d.sv]
// testbench for the 3d simplex noise block: directed table plus random points, with a predictor
`timescale 1ns / 1ps
`default_nettype none

module tb_simplex_noise_3d;
    import simp3_pkg::*;

    localparam longint ONE_FX = 64'sd1 << FRAC_BITS;
    localparam int N_RANDOM = 1600;
    localparam logic [5:0] HASH_TAB [8] = '{6'h15, 6'h38, 6'h32, 6'h2c,
                                            6'h0d, 6'h13, 6'h07, 6'h2a};

    typedef struct {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic                      fixed;
        logic signed [OUT_W-1:0]   noise;
    } point_row_t;

    logic clk;
    logic rst_n;

    simp3_point_if point_ch ();
    simp3_noise_if noise_ch ();

    simplex_noise_3d i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_ch.sink),
        .result (noise_ch.source)
    );

    logic signed [OUT_W-1:0] noise_expected [$];
    int  n_errors;
    int  n_results;
    int  n_sent;
    bit  hold_off;
    bit  stim_done;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic logic [8:0] cell_hash(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
        logic [7:0] co [3];
        logic [8:0] h;
        logic [2:0] idx;
        int r;
        co[0] = a;
        co[1] = b;
        co[2] = c;
        h = '0;
        for (int n = 0; n < 8; n++)
        begin
            r = n % 3;
            idx = {co[r][n], co[(r + 1) % 3][n], co[(r + 2) % 3][n]};
            h = h + 9'(HASH_TAB[idx]);
        end
        return h;
    endfunction

    function automatic longint corner_weight(input longint cellc [3], input longint off [3],
                                             input int cnt [3]);
        longint c [3];
        longint g [3];
        longint t5, tq, t2, t4, p, q, r, s;
        longint sa;
        logic [8:0] h;
        logic [1:0] sel;
        sa = cnt[0] + cnt[1] + cnt[2];
        for (int m = 0; m < 3; m++)
            c[m] = off[m] - 6 * ONE_FX * cnt[m] + sa * ONE_FX;
        t5 = 108 * ONE_FX * ONE_FX - 5 * (c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
        if (t5 <= 0)
            return 0;
        h = cell_hash(8'(cellc[0] + cnt[0]), 8'(cellc[1] + cnt[1]), 8'(cellc[2] + cnt[2]));
        tq = t5 / (180 * ONE_FX);
        t2 = (tq * tq) >>> FRAC_BITS;
        t4 = (t2 * t2) >>> FRAC_BITS;
        for (int m = 0; m < 3; m++)
            g[m] = floor_div(c[m], 6);
        sel = h[1:0];
        p = sel == 2'd1 ? g[0] : sel == 2'd2 ? g[1] : g[2];
        q = sel == 2'd1 ? g[1] : sel == 2'd2 ? g[2] : g[0];
        r = sel == 2'd1 ? g[2] : sel == 2'd2 ? g[0] : g[1];
        if (h[5] == h[3])
            p = -p;
        if (h[5] == h[4])
            q = -q;
        if (h[5] != (h[4] ^ h[3]))
            r = -r;
        s = p + (sel == 2'd0 ? q + r : (h[2] == 1'b0 ? q : r));
        return floor_div(8 * t4 * s, ONE_FX);
    endfunction

    function automatic logic signed [OUT_W-1:0] noise_at(input logic signed [COORD_W-1:0] px,
                                                         input logic signed [COORD_W-1:0] py,
                                                         input logic signed [COORD_W-1:0] pz);
        longint x, y, z, cs, total;
        longint cellc [3];
        longint off [3];
        int cnt [3];
        int hi, lo, mid;
        x = px;
        y = py;
        z = pz;
        cellc[0] = floor_div(4 * x + y + z, 3 * ONE_FX);
        cellc[1] = floor_div(x + 4 * y + z, 3 * ONE_FX);
        cellc[2] = floor_div(x + y + 4 * z, 3 * ONE_FX);
        cs = cellc[0] + cellc[1] + cellc[2];
        off[0] = 6 * x - 6 * ONE_FX * cellc[0] + cs * ONE_FX;
        off[1] = 6 * y - 6 * ONE_FX * cellc[1] + cs * ONE_FX;
        off[2] = 6 * z - 6 * ONE_FX * cellc[2] + cs * ONE_FX;
        hi = off[0] >= off[2] ? (off[0] >= off[1] ? 0 : 1) : (off[1] >= off[2] ? 1 : 2);
        lo = off[0] < off[2] ? (off[0] < off[1] ? 0 : 1) : (off[1] < off[2] ? 1 : 2);
        mid = 3 - hi - lo;
        cnt = '{0, 0, 0};
        total = corner_weight(cellc, off, cnt);
        cnt[hi]++;
        total += corner_weight(cellc, off, cnt);
        cnt[mid]++;
        total += corner_weight(cellc, off, cnt);
        cnt[lo]++;
        total += corner_weight(cellc, off, cnt);
        if (total > 131071)
            total = 131071;
        if (total < -131072)
            total = -131072;
        return OUT_W'(total);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            2: return 32'($signed($urandom_range(0, 1023)) - 512) <<< 14;
            3: return $urandom_range(0, 1) ? 32'h7fff_0000 + $urandom_range(0, 65535)
                                            : 32'h8000_0000 + $urandom_range(0, 65535);
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    // valid stays high across back-to-back items and drops only for a gap
    task automatic offer_point(input point_row_t row);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.px <= row.px;
        point_ch.py <= row.py;
        point_ch.pz <= row.pz;
        noise_expected.push_back(row.fixed ? row.noise : noise_at(row.px, row.py, row.pz));
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
        n_sent++;
    endtask

    // sender side
    initial
    begin
        point_row_t directed [$];
        point_row_t row;
        n_sent = 0;
        stim_done = 1'b0;
        hold_off = 1'b0;
        point_ch.valid = 1'b0;
        point_ch.px = '0;
        point_ch.py = '0;
        point_ch.pz = '0;
        rst_n = 1'b0;
        clk = 1'b0;
        directed = '{
            '{32'sh0, 32'sh0, 32'sh0, 1'b1, 18'sh0},
            '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1, 18'sh0},
            '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, 18'sh0},
            '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 18'sh0},
            '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 1'b0, 18'sh0},
            '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, 18'sh0},
            '{32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, 1'b0, 18'sh0},
            '{32'sh0000_8000, 32'sh0000_4000, 32'sh0000_2000, 1'b0, 18'sh0},
            '{32'sh0000_2000, 32'sh0000_8000, 32'sh0000_4000, 1'b0, 18'sh0},
            '{32'sh0000_4000, 32'sh0000_2000, 32'sh0000_8000, 1'b0, 18'sh0},
            '{32'sh0000_4000, 32'sh0000_8000, 32'sh0000_2000, 1'b0, 18'sh0},
            '{32'shffff_8000, 32'shffff_c000, 32'sh0000_3000, 1'b0, 18'sh0},
            '{32'sh0080_4000, 32'shff80_2000, 32'sh0100_6000, 1'b0, 18'sh0},
            '{32'sh00ff_8000, 32'sh0100_8000, 32'shff00_8000, 1'b0, 18'sh0},
            '{32'sh0000_5555, 32'sh0000_5555, 32'sh0000_5555, 1'b0, 18'sh0},
            '{32'sh1234_5678, 32'shedcb_a987, 32'sh5a5a_a5a5, 1'b0, 18'sh0}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[n])
            offer_point(directed[n]);
        point_ch.valid <= 1'b0;
        // drain fully before the random part
        while (noise_expected.size() != 0)
            @(posedge clk);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300)
                hold_off = 1'b1;
            if (n == 330)
                hold_off = 1'b0;
            row.fixed = 1'b0;
            row.noise = '0;
            row.px = rand_coord();
            row.py = rand_coord();
            row.pz = rand_coord();
            if (n % 500 < 40)
                begin
                    row.px = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
                    row.px = row.px ^ 32'($urandom_range(0, 255));
                end
            offer_point(row);
        end
        point_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver side
    initial
    begin
        int gap;
        n_errors = 0;
        n_results = 0;
        noise_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
                begin
                    noise_ch.ready <= 1'b0;
                    repeat (200) @(posedge clk);
                end
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
            if (gap != 0)
                begin
                    noise_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            noise_ch.ready <= 1'b1;
            @(posedge clk);
            while (!noise_ch.valid)
                @(posedge clk);
            n_results++;
            if (noise_expected.size() == 0)
                begin
                    $error("noise_value: unexpected item, actual %0d", noise_ch.noise_value);
                    n_errors++;
                end
            else if (noise_expected[0] !== noise_ch.noise_value)
                begin
                    $error("noise_value: expected %0d, actual %0d", noise_expected[0],
                           noise_ch.noise_value);
                    n_errors++;
                    void'(noise_expected.pop_front());
                end
            else
                void'(noise_expected.pop_front());
        end
    end

    // end of run
    initial
    begin
        @(posedge rst_n);
        while (!stim_done || noise_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d points and checked %0d noise items, with a long output stall",
                 n_sent, n_results);
        if (n_errors == 0)
            $display("tb_simplex_noise_3d: done, clean");
        else
            $display("tb_simplex_noise_3d: done, errors");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("tb_simplex_noise_3d: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
